[src/sscc_pkg.sv]
package sscc_pkg;

  // Request codes carried in req_type.
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Register numbers carried in reg_index.
  localparam logic [2:0] REG_SWEEP = 3'd0;
  localparam logic [2:0] REG_DUTY  = 3'd1;
  localparam logic [2:0] REG_ENV   = 3'd2;
  localparam logic [2:0] REG_FLO   = 3'd3;
  localparam logic [2:0] REG_CTL   = 3'd4;

  localparam logic [10:0] FREQ_MAX    = 11'h7FF;
  localparam logic [11:0] PERIOD_BASE = 12'd2048;
  localparam logic [6:0]  LENGTH_FULL = 7'd64;
  localparam logic [3:0]  VOL_MAX     = 4'd15;
  localparam logic [3:0]  ENV_DEFAULT = 4'd8;
  localparam logic [7:0]  RD_UNUSED   = 8'hFF;
  localparam logic [7:0]  RD_DUTY_OR  = 8'h3F;
  localparam logic [7:0]  RD_CTL_OR   = 8'hBF;
  localparam logic [7:0]  MASK_DUTY   = 8'hC0;
  localparam logic [7:0]  MASK_LENEN  = 8'h40;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] reg_index;
    logic [7:0] write_data;
    logic       length_strobe;
    logic       envelope_strobe;
    logic       sweep_strobe;
  } in_item_t;

  typedef struct packed {
    logic [3:0] level;
    logic       channel_on;
    logic [7:0] read_data;
  } out_item_t;

  // Result of one frequency sweep computation.
  typedef struct packed {
    logic        ovf;
    logic [10:0] next_freq;
  } sweep_res_t;

  // Eight-step waveform for each of the four duty settings.
  function automatic logic [7:0] duty_pattern(input logic [1:0] duty);
    logic [7:0] pat;
    case (duty)
      2'd0:    pat = 8'b0000_0001;
      2'd1:    pat = 8'b1000_0001;
      2'd2:    pat = 8'b1000_0111;
      default: pat = 8'b0111_1110;
    endcase
    return pat;
  endfunction

endpackage

[src/square_sweep_sound_channel_core.sv]
// Square-wave sound channel with frequency sweep, volume envelope and length
// counter. Each input transaction is a tick (with length, envelope and sweep
// clock strobes), a write of one of the five byte registers, or a register
// read; every input transaction yields exactly one output transaction that
// carries the 4-bit level, the channel enable flag and, for reads, the masked
// readback byte. The block takes one transaction per clock cycle while the
// output is not stalled. Each accepted transaction passes through the input
// register, where the whole state update for the transaction is evaluated,
// and then through the output register. That state update covers the
// length counter, envelope, two chained sweep steps and the period timer.
// Backpressure on the output stalls the input register, which keeps
// accepting as long as the output register drains.
module square_sweep_sound_channel_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sscc_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output sscc_pkg::out_item_t out_item
);
  import sscc_pkg::*;

  logic      s0_valid_r;
  in_item_t  s0_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t result;
  logic      s0_adv;

  // The held transaction moves on whenever the output register is free or
  // is being emptied in the same cycle.
  assign s0_adv   = s0_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s0_valid_r || s0_adv;

  // The channel state changes only when a transaction leaves the input
  // register, so each one sees the state left by its predecessor.
  sscc_channel u_channel (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_vld (s0_adv),
    .item     (s0_item_r),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s0_valid_r <= 1'b1;
      end else if (s0_adv) begin
        s0_valid_r <= 1'b0;
      end
      if (s0_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_item_r <= in_item;
    end
    if (s0_adv) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  a_off_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_item_r.channel_on) |-> (out_item_r.level == '0))
    else $error("disabled channel reports a nonzero level");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s0_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without a full pipeline");

  a_accept_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s0_valid_r)
    else $error("accepted transaction not held in the input register");

  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    s0_adv |=> out_valid_r)
    else $error("advanced transaction produced no result");
`endif

endmodule

[src/sscc_sweep_calc.sv]
module sscc_sweep_calc (
  input  logic [10:0]        freq,
  input  logic [2:0]         shift,
  input  logic               subtract,
  output sscc_pkg::sweep_res_t res
);
  import sscc_pkg::*;

  logic [10:0] delta;
  logic [11:0] sum;

  // The shifted value never exceeds the frequency, so subtraction cannot
  // underflow and only addition can overflow past eleven bits.
  assign delta = freq >> shift;
  assign sum   = subtract ? ({1'b0, freq} - {1'b0, delta}) : ({1'b0, freq} + {1'b0, delta});
  assign res.ovf       = sum[11];
  assign res.next_freq = sum[10:0];

endmodule

[src/sscc_channel.sv]
module sscc_channel (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_vld,
  input  sscc_pkg::in_item_t  item,
  output sscc_pkg::out_item_t result
);
  import sscc_pkg::*;

  logic [7:0]  reg_sweep_r, reg_sweep_nxt;
  logic [7:0]  reg_duty_r, reg_duty_nxt;
  logic [7:0]  reg_env_r, reg_env_nxt;
  logic [7:0]  reg_flo_r, reg_flo_nxt;
  logic [7:0]  reg_ctl_r, reg_ctl_nxt;
  logic [6:0]  length_left_r, length_left_nxt;
  logic [3:0]  env_cd_r, env_cd_nxt;
  logic [3:0]  volume_r, volume_nxt;
  logic [10:0] shadow_freq_r, shadow_freq_nxt;
  logic [2:0]  sweep_cd_r, sweep_cd_nxt;
  logic        sweep_active_r, sweep_active_nxt;
  logic [11:0] period_r, period_nxt;
  logic [2:0]  duty_step_r, duty_step_nxt;
  logic        enabled_r, enabled_nxt;

  logic [10:0] trig_freq;
  logic [10:0] sweep2_freq;
  sweep_res_t  trig_chk, sweep1, sweep2;
  logic [2:0]  pace;
  logic [2:0]  env_per;
  logic [7:0]  rd_data;
  logic [7:0]  duty_pat;

  assign pace      = reg_sweep_r[6:4];
  assign env_per   = reg_env_r[2:0];
  assign trig_freq = {item.write_data[2:0], reg_flo_r};

  // Overflow check at trigger, then the committing step and the check that
  // follows it on a sweep clock.
  sscc_sweep_calc u_trig_chk (
    .freq     (trig_freq),
    .shift    (reg_sweep_r[2:0]),
    .subtract (reg_sweep_r[3]),
    .res      (trig_chk)
  );

  sscc_sweep_calc u_sweep1 (
    .freq     (shadow_freq_r),
    .shift    (reg_sweep_r[2:0]),
    .subtract (reg_sweep_r[3]),
    .res      (sweep1)
  );

  assign sweep2_freq = sweep1.ovf ? shadow_freq_r : sweep1.next_freq;

  sscc_sweep_calc u_sweep2 (
    .freq     (sweep2_freq),
    .shift    (reg_sweep_r[2:0]),
    .subtract (reg_sweep_r[3]),
    .res      (sweep2)
  );

  always_comb begin
    reg_sweep_nxt    = reg_sweep_r;
    reg_duty_nxt     = reg_duty_r;
    reg_env_nxt      = reg_env_r;
    reg_flo_nxt      = reg_flo_r;
    reg_ctl_nxt      = reg_ctl_r;
    length_left_nxt  = length_left_r;
    env_cd_nxt       = env_cd_r;
    volume_nxt       = volume_r;
    shadow_freq_nxt  = shadow_freq_r;
    sweep_cd_nxt     = sweep_cd_r;
    sweep_active_nxt = sweep_active_r;
    period_nxt       = period_r;
    duty_step_nxt    = duty_step_r;
    enabled_nxt      = enabled_r;
    rd_data          = '0;

    unique case (item.req_type)
      REQ_TICK: begin
        if (item.length_strobe && enabled_r && reg_ctl_r[6]) begin
          if (length_left_r != '0) begin
            length_left_nxt = length_left_r - 7'd1;
          end
          enabled_nxt = (length_left_nxt != '0);
        end

        if (item.envelope_strobe && env_cd_r != '0) begin
          env_cd_nxt = env_cd_r - 4'd1;
          if (env_cd_r == 4'd1 && env_per != '0) begin
            if (reg_env_r[3] && volume_r != VOL_MAX) begin
              volume_nxt = volume_r + 4'd1;
              env_cd_nxt = {1'b0, env_per};
            end else if (!reg_env_r[3] && volume_r != '0) begin
              volume_nxt = volume_r - 4'd1;
              env_cd_nxt = {1'b0, env_per};
            end
          end
        end

        if (item.sweep_strobe && sweep_cd_r != '0) begin
          sweep_cd_nxt = sweep_cd_r - 3'd1;
          if (sweep_cd_r == 3'd1 && sweep_active_r && pace != '0) begin
            sweep_cd_nxt = pace;
            if (sweep1.ovf) begin
              enabled_nxt = 1'b0;
            end else begin
              shadow_freq_nxt = sweep1.next_freq;
              reg_flo_nxt     = sweep1.next_freq[7:0];
              reg_ctl_nxt     = {reg_ctl_r[7:3], sweep1.next_freq[10:8]};
            end
            if (sweep2.ovf) begin
              enabled_nxt = 1'b0;
            end
          end
        end

        if (period_r <= 12'd1) begin
          period_nxt    = PERIOD_BASE - {1'b0, shadow_freq_nxt & FREQ_MAX};
          duty_step_nxt = duty_step_r + 3'd1;
        end else begin
          period_nxt = period_r - 12'd1;
        end
      end

      REQ_WRITE: begin
        unique case (item.reg_index)
          REG_SWEEP: reg_sweep_nxt = item.write_data;
          REG_DUTY: begin
            reg_duty_nxt    = item.write_data;
            length_left_nxt = LENGTH_FULL - {1'b0, item.write_data[5:0]};
          end
          REG_ENV:   reg_env_nxt = item.write_data;
          REG_FLO:   reg_flo_nxt = item.write_data;
          REG_CTL: begin
            reg_ctl_nxt = item.write_data;
            if (item.write_data[7]) begin
              enabled_nxt = 1'b1;
              if (length_left_r == '0) begin
                length_left_nxt = LENGTH_FULL;
              end
              period_nxt       = PERIOD_BASE - {1'b0, trig_freq};
              env_cd_nxt       = (env_per != '0) ? {1'b0, env_per} : ENV_DEFAULT;
              volume_nxt       = reg_env_r[7:4];
              shadow_freq_nxt  = trig_freq;
              sweep_cd_nxt     = pace;
              sweep_active_nxt = (pace != '0) || (reg_sweep_r[2:0] != '0);
              if (reg_sweep_r[2:0] != '0 && trig_chk.ovf) begin
                enabled_nxt = 1'b0;
              end
            end
          end
          default: ;
        endcase
      end

      REQ_READ: begin
        unique case (item.reg_index)
          REG_SWEEP: rd_data = reg_sweep_r;
          REG_DUTY:  rd_data = (reg_duty_r & MASK_DUTY) | RD_DUTY_OR;
          REG_ENV:   rd_data = reg_env_r;
          REG_FLO:   rd_data = RD_UNUSED;
          REG_CTL:   rd_data = (reg_ctl_r & MASK_LENEN) | RD_CTL_OR;
          default:   rd_data = RD_UNUSED;
        endcase
      end

      default: ;
    endcase
  end

  assign duty_pat = duty_pattern(reg_duty_nxt[7:6]);

  always_comb begin
    result.level      = (enabled_nxt && duty_pat[duty_step_nxt]) ? volume_nxt : '0;
    result.channel_on = enabled_nxt;
    result.read_data  = rd_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_sweep_r    <= '0;
      reg_duty_r     <= '0;
      reg_env_r      <= '0;
      reg_flo_r      <= '0;
      reg_ctl_r      <= '0;
      length_left_r  <= '0;
      env_cd_r       <= '0;
      volume_r       <= '0;
      shadow_freq_r  <= '0;
      sweep_cd_r     <= '0;
      sweep_active_r <= 1'b0;
      period_r       <= '0;
      duty_step_r    <= '0;
      enabled_r      <= 1'b0;
    end else if (item_vld) begin
      reg_sweep_r    <= reg_sweep_nxt;
      reg_duty_r     <= reg_duty_nxt;
      reg_env_r      <= reg_env_nxt;
      reg_flo_r      <= reg_flo_nxt;
      reg_ctl_r      <= reg_ctl_nxt;
      length_left_r  <= length_left_nxt;
      env_cd_r       <= env_cd_nxt;
      volume_r       <= volume_nxt;
      shadow_freq_r  <= shadow_freq_nxt;
      sweep_cd_r     <= sweep_cd_nxt;
      sweep_active_r <= sweep_active_nxt;
      period_r       <= period_nxt;
      duty_step_r    <= duty_step_nxt;
      enabled_r      <= enabled_nxt;
    end
  end

endmodule
